// ===== rtl/sle_pkg.sv =====
// sle_pkg: shared types, character codes and escape sequences for the
// serial line editor. No dependencies.
`timescale 1ns / 1ps

package sle_pkg;

  // character codes
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_BS    = 8'd8;
  localparam logic [7:0] CHAR_DEL   = 8'd127;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_ESC   = 8'd27;
  localparam logic [7:0] CHAR_LBRK  = 8'd91;
  localparam logic [7:0] CHAR_3     = 8'd51;
  localparam logic [7:0] CHAR_1     = 8'd49;
  localparam logic [7:0] CHAR_0     = 8'd48;
  localparam logic [7:0] CHAR_M     = 8'd109;

  localparam logic [7:0] CAPACITY_RESET = 8'd32;
  localparam logic [7:0] COUNT_MAX      = 8'd255;

  // step of the last result for each kind of byte, and the erase space step
  localparam logic [3:0] STEP_SINGLE    = 4'd0;
  localparam logic [3:0] STEP_ERASE_END = 4'd2;
  localparam logic [3:0] STEP_RED_END   = 4'd9;
  localparam logic [3:0] STEP_ERASE_SP  = 4'd1;

  // kind of received byte
  typedef enum logic [1:0] {
    KIND_LINE,
    KIND_ERASE,
    KIND_ECHO,
    KIND_RED
  } kind_t;

  // everything the emitter needs to send the results of one byte
  typedef struct packed {
    kind_t      kind;
    logic [7:0] rx_byte;
    logic       erase_echo;
    logic       erase_write;
    logic [7:0] index;
    logic       overflow;
    logic [3:0] last_step;
  } desc_t;

  // one result transaction
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       store_write;
    logic [7:0] store_index;
    logic [7:0] store_byte;
    logic       line_done;
    logic       line_overflow;
    logic       last;
  } result_t;

  // byte sent at a given step of the red-wrapped echo
  function automatic logic [7:0] red_seq_byte(input logic [3:0] step,
                                              input logic [7:0] c);
    logic [7:0] b;
    unique case (step)
      4'd0:    b = CHAR_ESC;
      4'd1:    b = CHAR_LBRK;
      4'd2:    b = CHAR_3;
      4'd3:    b = CHAR_1;
      4'd4:    b = CHAR_M;
      4'd5:    b = c;
      4'd6:    b = CHAR_ESC;
      4'd7:    b = CHAR_LBRK;
      4'd8:    b = CHAR_0;
      4'd9:    b = CHAR_M;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/sle_ctrl.sv =====
// sle_ctrl: capacity register, character count and per-byte decode.
// Depends on sle_pkg.
`timescale 1ns / 1ps

module sle_ctrl
  import sle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output desc_t      desc
);

  logic [7:0] capacity_r, capacity_nxt;
  logic [7:0] count_r, count_nxt;
  logic [7:0] erase_count;

  assign cfg_ready = 1'b1;

  // decode the byte against the current count
  always_comb begin
    desc             = '0;
    desc.rx_byte     = rx_byte;
    count_nxt        = count_r;
    erase_count      = (count_r != 8'd0) ? (count_r - 8'd1) : count_r;
    if ((rx_byte == CHAR_CR) || (rx_byte == CHAR_LF)) begin
      desc.kind      = KIND_LINE;
      desc.overflow  = (count_r > capacity_r);
      desc.last_step = STEP_SINGLE;
      count_nxt      = 8'd0;
    end else if ((rx_byte == CHAR_DEL) || (rx_byte == CHAR_BS)) begin
      desc.kind        = KIND_ERASE;
      desc.erase_echo  = (count_r != 8'd0);
      desc.erase_write = (erase_count < capacity_r);
      desc.index       = erase_count;
      desc.last_step   = (count_r != 8'd0) ? STEP_ERASE_END : STEP_SINGLE;
      count_nxt        = erase_count;
    end else if (count_r < capacity_r) begin
      desc.kind      = KIND_ECHO;
      desc.index     = count_r;
      desc.last_step = STEP_SINGLE;
      count_nxt      = count_r + 8'd1;
    end else begin
      desc.kind      = KIND_RED;
      desc.last_step = STEP_RED_END;
      count_nxt      = (count_r != COUNT_MAX) ? (count_r + 8'd1) : count_r;
    end
  end

  // capacity register write
  always_comb begin
    capacity_nxt = capacity_r;
    if (cfg_valid && cfg_ready) begin
      capacity_nxt = cfg_data;
    end
  end

  // count and capacity registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAPACITY_RESET;
      count_r    <= 8'd0;
    end else begin
      capacity_r <= capacity_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

endmodule

// ===== rtl/sle_emit.sv =====
// sle_emit: holds one decoded byte and steps through its results into
// the output register. Depends on sle_pkg.
`timescale 1ns / 1ps

module sle_emit
  import sle_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    accept,
  output logic    ready,
  input  desc_t   desc,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_res
);

  desc_t      desc_r;
  logic       busy_r, busy_nxt;
  logic [3:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  result_t    res_r;
  result_t    res_nxt;
  logic       load;
  logic       final_step;

  assign load       = busy_r && (!out_valid_r || !out_stall);
  assign final_step = (step_r == desc_r.last_step);
  assign ready      = !busy_r || (load && final_step);
  assign out_valid  = out_valid_r;
  assign out_res    = res_r;

  // build the result at the current step
  always_comb begin
    res_nxt = '0;
    unique case (desc_r.kind)
      KIND_LINE: begin
        res_nxt.line_done     = 1'b1;
        res_nxt.line_overflow = desc_r.overflow;
      end
      KIND_ECHO: begin
        res_nxt.tx_valid    = 1'b1;
        res_nxt.tx_byte     = desc_r.rx_byte;
        res_nxt.store_write = 1'b1;
        res_nxt.store_index = desc_r.index;
        res_nxt.store_byte  = desc_r.rx_byte;
      end
      KIND_RED: begin
        res_nxt.tx_valid = 1'b1;
        res_nxt.tx_byte  = red_seq_byte(step_r, desc_r.rx_byte);
      end
      KIND_ERASE: begin
        if (desc_r.erase_echo) begin
          res_nxt.tx_valid = 1'b1;
          res_nxt.tx_byte  = (step_r == STEP_ERASE_SP) ? CHAR_SPACE : CHAR_BS;
        end
        // zero write rides on the last result
        if (final_step && desc_r.erase_write) begin
          res_nxt.store_write = 1'b1;
          res_nxt.store_index = desc_r.index;
        end
      end
      default: res_nxt = '0;
    endcase
    res_nxt.last = final_step;
  end

  // sequencer next state
  always_comb begin
    busy_nxt      = busy_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      step_nxt      = step_r + 4'd1;
      if (final_step) begin
        busy_nxt = 1'b0;
      end
    end
    if (accept) begin
      busy_nxt = 1'b1;
      step_nxt = 4'd0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      desc_r <= desc;
    end
    if (load) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ===== rtl/serial_line_editor.sv =====
// serial_line_editor: top level of the terminal line editor.
// Depends on sle_pkg, sle_ctrl and sle_emit.
//
//   channel  handshake             payload
//   in       in_valid / in_stall   in_rx_byte
//   out      out_valid / out_stall out_tx_*, out_store_*, out_line_*, out_last
//   cfg      cfg_valid / cfg_ready cfg_data (line capacity)
//
// Each received byte gives 1 to 10 result transactions, one per cycle from
// the emit sequencer while out_stall is low, so one-result bytes flow at
// one per cycle; the input stalls until the last result of a byte is loaded.
// Synchronous active-low reset clears count to 0 and capacity to 32.
// out_stall holds the output register; the next byte is taken while the
// last result of the previous one waits.
`timescale 1ns / 1ps

module serial_line_editor
  import sle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_tx_valid,
  output logic [7:0] out_tx_byte,
  output logic       out_store_write,
  output logic [7:0] out_store_index,
  output logic [7:0] out_store_byte,
  output logic       out_line_done,
  output logic       out_line_overflow,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  desc_t   desc;
  result_t res;
  logic    ready;
  logic    accept;

  // input transaction
  assign in_stall = !ready;
  assign accept   = in_valid && ready;

  sle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .rx_byte   (in_rx_byte),
    .desc      (desc)
  );

  sle_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .ready     (ready),
    .desc      (desc),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  // unpack the result fields
  assign out_tx_valid      = res.tx_valid;
  assign out_tx_byte       = res.tx_byte;
  assign out_store_write   = res.store_write;
  assign out_store_index   = res.store_index;
  assign out_store_byte    = res.store_byte;
  assign out_line_done     = res.line_done;
  assign out_line_overflow = res.line_overflow;
  assign out_last          = res.last;

endmodule
